// ----- src/gha_pkg.sv -----
`timescale 1ns / 1ps
// Shared codes and default sizes for the generational handle allocator.
package gha_pkg;

    localparam int unsigned SlotsDefault   = 1024;
    localparam int unsigned GenBitsDefault = 16;

    // Field widths of the stream beats
    localparam int unsigned ActionW = 2;
    localparam int unsigned IdW     = 10;
    localparam int unsigned GenW    = 16;
    localparam int unsigned StatusW = 2;
    localparam int unsigned BeatW   = 32;

    typedef enum logic [ActionW-1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [StatusW-1:0] {
        STS_OK     = 2'd0,
        STS_STALE  = 2'd1,
        STS_FULL   = 2'd2,
        STS_RANGE  = 2'd3
    } status_t;

endpackage

// ----- src/generational_handle_allocator_unit.sv -----
`timescale 1ns / 1ps
// Generational handle allocator: slot table with LIFO free list and stale-handle checks.
// Per item: slot read into the memory's read register, then check and write back, with the
// result registered. Items pass one at a time through the single read-modify-write pass of
// the slot memory; a result not yet taken holds the execute step until the sink takes it.
// Reset (aresetn low, synchronous): free list empty, slot 0 reserved, no result pending.
// The slot memory itself is not cleared; entries are only read after being written.
module generational_handle_allocator_unit
    import gha_pkg::*;
#(
    parameter int unsigned SLOTS    = SlotsDefault,
    parameter int unsigned GEN_BITS = GenBitsDefault
) (
    input  logic             aclk,
    input  logic             aresetn,
    // action [1:0], handle_id [11:2], handle_generation [27:12], zero pad [31:28]
    input  logic [BeatW-1:0] s_tdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // status [1:0], result_id [11:2], result_generation [27:12], zero pad [31:28]
    output logic [BeatW-1:0] m_tdata,
    output logic             m_tvalid,
    input  logic             m_tready
);

    // Slot index and counter widths; comparison widths cover both the port id and the count
    localparam int unsigned SlotW  = $clog2(SLOTS);
    localparam int unsigned CntW   = SlotW + 1;
    localparam int unsigned CmpW   = (CntW > IdW) ? CntW : IdW;
    localparam int unsigned GenCmp = (GEN_BITS > GenW) ? GEN_BITS : GenW;

    // Entry layout: {active, generation, next free link}
    localparam int unsigned EntryW  = 1 + GEN_BITS + SlotW;
    localparam int unsigned GenLo   = SlotW;
    localparam int unsigned ActBit  = SlotW + GEN_BITS;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t               state_reg;
    action_t              act_reg;
    logic [IdW-1:0]       hid_reg;
    logic [GenW-1:0]      hgen_reg;
    logic [SlotW-1:0]     free_head_reg, free_head_next;
    logic [CntW-1:0]      used_count_reg, used_count_next;
    logic [BeatW-1:0]     m_tdata_reg, m_tdata_next;
    logic                 m_tvalid_reg;

    logic                 s_accept;
    logic                 exec_go;
    action_t              in_action;
    logic [IdW-1:0]       in_hid;
    logic [SlotW-1:0]     in_slot;
    logic [SlotW-1:0]     rd_addr;

    logic                 ram_we;
    logic [SlotW-1:0]     ram_waddr;
    logic [EntryW-1:0]    ram_wdata;
    logic [EntryW-1:0]    ram_rdata;

    logic [SlotW-1:0]     hid_slot;
    logic                 hid_zero;
    logic                 out_of_range;
    logic                 entry_active;
    logic [GEN_BITS-1:0]  entry_gen;
    logic [SlotW-1:0]     entry_link;
    logic [GenCmp-1:0]    hgen_wide;
    logic [GEN_BITS-1:0]  hgen_masked;
    logic                 handle_ok;
    logic [GEN_BITS-1:0]  gen_bumped;
    logic [GEN_BITS-1:0]  gen_report;
    logic [GenCmp-1:0]    gen_report_wide;
    status_t              sts;
    logic [IdW-1:0]       out_id;

    // Input side: one item at a time, no beat taken while reset is held;
    // the slot read is issued on the accepting edge
    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_action = action_t'(s_tdata[ActionW-1:0]);
    assign in_hid    = s_tdata[ActionW +: IdW];
    assign in_slot   = CmpW'(in_hid) >> 0 == '0 ? '0 : SlotW'(CmpW'(in_hid));
    // Allocate reads the free-list head, free and lookup read the handle's own slot
    assign rd_addr   = (in_action == ACT_ALLOC) ? free_head_reg : in_slot;

    // Execute step waits only while an earlier result still sits in the output register
    assign exec_go   = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

    gha_slot_ram #(
        .DEPTH (SLOTS),
        .WIDTH (EntryW)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // Handle checks on the registered slot entry; the reserved slot always reads inactive
    assign hid_slot     = SlotW'(CmpW'(hid_reg));
    assign hid_zero     = (hid_reg == '0);
    assign out_of_range = (CmpW'(hid_reg) >= CmpW'(used_count_reg));
    assign entry_active = hid_zero ? 1'b0 : ram_rdata[ActBit];
    assign entry_gen    = hid_zero ? '0 : ram_rdata[GenLo +: GEN_BITS];
    assign entry_link   = ram_rdata[SlotW-1:0];
    assign hgen_wide    = GenCmp'(hgen_reg);
    assign hgen_masked  = hgen_wide[GEN_BITS-1:0];
    assign handle_ok    = entry_active && (entry_gen == hgen_masked);
    assign gen_bumped   = entry_gen + GEN_BITS'(1);

    always_comb begin
        free_head_next  = free_head_reg;
        used_count_next = used_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = hid_slot;
        ram_wdata       = {1'b0, gen_bumped, free_head_reg};
        sts             = STS_OK;
        out_id          = hid_reg;
        gen_report      = '0;

        unique case (act_reg)
            ACT_ALLOC: begin
                priority if (free_head_reg != '0) begin
                    // pop the free list; the slot keeps its bumped generation
                    ram_we         = 1'b1;
                    ram_waddr      = free_head_reg;
                    ram_wdata      = {1'b1, ram_rdata[GenLo +: GEN_BITS], entry_link};
                    free_head_next = entry_link;
                    out_id         = IdW'(free_head_reg);
                    gen_report     = ram_rdata[GenLo +: GEN_BITS];
                end else if (used_count_reg != CntW'(SLOTS)) begin
                    // take the next fresh slot at generation zero
                    ram_we          = 1'b1;
                    ram_waddr       = SlotW'(used_count_reg);
                    ram_wdata       = {1'b1, {GEN_BITS{1'b0}}, {SlotW{1'b0}}};
                    used_count_next = used_count_reg + CntW'(1);
                    out_id          = IdW'(used_count_reg);
                end else begin
                    sts = STS_FULL;
                end
            end
            ACT_CLEAR: begin
                free_head_next  = '0;
                used_count_next = CntW'(1);
            end
            default: begin
                // free or lookup
                priority if (out_of_range) begin
                    sts = STS_RANGE;
                end else if (!handle_ok) begin
                    sts        = STS_STALE;
                    gen_report = entry_gen;
                end else if (act_reg == ACT_FREE) begin
                    // retire the handle and push the slot on the free list
                    ram_we         = 1'b1;
                    free_head_next = hid_slot;
                    gen_report     = gen_bumped;
                end else begin
                    gen_report = entry_gen;
                end
            end
        endcase

        // only commit when the execute step actually retires
        ram_we = ram_we && exec_go;
    end

    assign gen_report_wide = GenCmp'(gen_report);
    assign m_tdata_next    = BeatW'({gen_report_wide[GenW-1:0], out_id, sts});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            free_head_reg  <= '0;
            used_count_reg <= CntW'(1);
            m_tvalid_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (exec_go) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (exec_go) begin
                free_head_reg  <= free_head_next;
                used_count_reg <= used_count_next;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                // drop the result once the sink has taken it
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: latch the item on accept, the result on retire
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg  <= in_action;
            hid_reg  <= in_hid;
            hgen_reg <= s_tdata[ActionW+IdW +: GenW];
        end
        if (exec_go) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    // The fresh-slot counter stays between one (slot zero reserved) and the table size
    a_count_bounds : assert property (@(posedge aclk) disable iff (!aresetn)
        (used_count_reg >= CntW'(1)) && (used_count_reg <= CntW'(SLOTS)))
        else $error("used count outside table bounds");

    // Every slot on the free list has been handed out before, so the head lies below the count
    a_head_below_count : assert property (@(posedge aclk) disable iff (!aresetn)
        (free_head_reg == '0) || (CntW'(free_head_reg) < used_count_reg))
        else $error("free-list head beyond allocated slots");

    // A new result appears only after an execute step
    a_result_after_exec : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result raised without execute step");

    // No new item while an execute step is pending
    a_one_in_flight : assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_EXEC) && !s_tready)
        else $error("item accepted with execute pending");

endmodule

// ----- src/gha_slot_ram.sv -----
`timescale 1ns / 1ps
// Single-port-write, registered-read slot table memory.
module gha_slot_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 27
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data until the next read
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- verif/generational_handle_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the generational handle allocator with a slot table predictor.
module generational_handle_allocator_unit_tb;
    import gha_pkg::*;

    localparam int unsigned SLOTS     = SlotsDefault;
    localparam int unsigned HOLD_LEN  = 40;   // long receiver hold-off, in cycles
    localparam int unsigned RAND_ITEMS = 410;
    localparam int unsigned QUIET_TAIL = 60;  // final random items with no idling
    localparam int unsigned MAX_SHOWN = 10;

    // Result beat fields, lowest bits last so the struct maps straight onto tdata
    typedef struct packed {
        logic [GenW-1:0] gen;
        logic [IdW-1:0]  id;
        status_t         sts;
    } result_t;

    typedef struct packed {
        logic [IdW-1:0]  id;
        logic [GenW-1:0] gen;
    } handle_t;

    // One row of the directed table; want is only used where pinned is set
    typedef struct {
        action_t         act;
        logic [IdW-1:0]  hid;
        logic [GenW-1:0] hgen;
        bit              pinned;
        result_t         want;
    } vector_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic [BeatW-1:0] s_tdata  = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [BeatW-1:0] m_tdata;
    logic             m_tvalid;
    logic             m_tready = 1'b0;

    generational_handle_allocator_unit #(
        .SLOTS    (SlotsDefault),
        .GEN_BITS (GenBitsDefault)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor: shadow copy of the slot table
    // ------------------------------------------------------------------
    bit              shadow_active [SLOTS];
    bit [GenW-1:0]   shadow_gen    [SLOTS];
    bit [IdW-1:0]    shadow_link   [SLOTS];
    bit [IdW-1:0]    shadow_head;
    int unsigned     shadow_used;

    result_t         pending_results [$];
    handle_t         live_handles    [$];
    handle_t         retired_handles [$];
    vector_t         vectors         [$];

    int unsigned     fault_count   = 0;
    int unsigned     mismatch_seen = 0;
    int unsigned     items_sent    = 0;
    int unsigned     results_seen  = 0;

    bit              src_idle_on  = 1'b1;
    bit              sink_idle_on = 1'b1;
    int unsigned     hold_reqs    = 0;

    // Empty the free list and reserve slot zero
    function automatic void shadow_clear();
        shadow_head      = '0;
        shadow_used      = 1;
        shadow_active[0] = 1'b0;
        shadow_gen[0]    = '0;
    endfunction

    // Apply one action to the shadow table and return the result it causes
    function automatic result_t slot_table_step(action_t act, logic [IdW-1:0] hid,
                                                logic [GenW-1:0] hgen);
        result_t         res;
        logic [IdW-1:0]  slot;
        logic [GenW-1:0] stored;
        res = '0;
        res.id = hid;
        case (act)
            ACT_ALLOC: begin
                if (shadow_head != 0) begin
                    slot        = shadow_head;
                    shadow_head = shadow_link[slot];
                end else if (shadow_used < SLOTS) begin
                    slot             = shadow_used[IdW-1:0];
                    shadow_used      = shadow_used + 1;
                    shadow_gen[slot] = '0;
                end else begin
                    res.sts = STS_FULL;
                    return res;
                end
                shadow_active[slot] = 1'b1;
                res.sts = STS_OK;
                res.id  = slot;
                res.gen = shadow_gen[slot];
            end
            ACT_CLEAR: begin
                shadow_clear();
                res.sts = STS_OK;
            end
            default: begin
                if (hid >= shadow_used) begin
                    res.sts = STS_RANGE;
                    return res;
                end
                stored  = shadow_gen[hid];
                res.gen = stored;
                if (!shadow_active[hid] || stored != hgen) begin
                    res.sts = STS_STALE;
                    return res;
                end
                if (act == ACT_FREE) begin
                    stored             = stored + 1'b1;
                    shadow_gen[hid]    = stored;
                    shadow_active[hid] = 1'b0;
                    shadow_link[hid]   = shadow_head;
                    shadow_head        = hid;
                    res.gen            = stored;
                end
                res.sts = STS_OK;
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Source side: one beat per call, optional idle burst before it
    // ------------------------------------------------------------------
    task automatic send_item(input action_t act, input logic [IdW-1:0] hid,
                             input logic [GenW-1:0] hgen, input bit pinned,
                             input result_t pin);
        int unsigned gap;
        result_t     pred;
        @(negedge aclk);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(BeatW - ActionW - IdW - GenW){1'b0}}, hgen, hid, act};
        // hold the beat until the block takes it
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        pred = slot_table_step(act, hid, hgen);
        pending_results.push_back(pinned ? pin : pred);
        // keep the handle pools in step with the table
        if (act == ACT_CLEAR) begin
            live_handles.delete();
        end else if (act == ACT_ALLOC && pred.sts == STS_OK) begin
            live_handles.push_back('{id: pred.id, gen: pred.gen});
        end else if (act == ACT_FREE && pred.sts == STS_OK) begin
            for (int i = 0; i < live_handles.size(); i++) begin
                if (live_handles[i].id == hid) begin
                    live_handles.delete(i);
                    break;
                end
            end
            if (retired_handles.size() < 64)
                retired_handles.push_back('{id: hid, gen: hgen});
        end
    endtask

    task automatic issue(input action_t act, input logic [IdW-1:0] hid,
                         input logic [GenW-1:0] hgen);
        send_item(act, hid, hgen, 1'b0, '0);
    endtask

    // Pause the source until every expected result has come back
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic add_vector(input action_t act, input logic [IdW-1:0] hid,
                              input logic [GenW-1:0] hgen, input bit pinned,
                              input status_t sts, input logic [IdW-1:0] rid,
                              input logic [GenW-1:0] rgen);
        vector_t v;
        v.act    = act;
        v.hid    = hid;
        v.hgen   = hgen;
        v.pinned = pinned;
        v.want   = '{gen: rgen, id: rid, sts: sts};
        vectors.push_back(v);
    endtask

    // Directed table: reserved slot, range, LIFO reuse, stale and double free, clear
    task automatic load_vectors();
        add_vector(ACT_LOOKUP, 10'd0,    16'h0000, 1, STS_STALE, 10'd0,    16'h0000);
        add_vector(ACT_FREE,   10'd0,    16'hFFFF, 1, STS_STALE, 10'd0,    16'h0000);
        add_vector(ACT_LOOKUP, 10'd1,    16'h0000, 1, STS_RANGE, 10'd1,    16'h0000);
        add_vector(ACT_FREE,   10'd1023, 16'hFFFF, 1, STS_RANGE, 10'd1023, 16'h0000);
        add_vector(ACT_ALLOC,  10'd1023, 16'hFFFF, 1, STS_OK,    10'd1,    16'h0000);
        add_vector(ACT_ALLOC,  10'd0,    16'h0000, 1, STS_OK,    10'd2,    16'h0000);
        add_vector(ACT_ALLOC,  10'd0,    16'h0000, 1, STS_OK,    10'd3,    16'h0000);
        add_vector(ACT_LOOKUP, 10'd1,    16'h0000, 1, STS_OK,    10'd1,    16'h0000);
        add_vector(ACT_LOOKUP, 10'd1,    16'hFFFF, 1, STS_STALE, 10'd1,    16'h0000);
        add_vector(ACT_FREE,   10'd2,    16'h0000, 1, STS_OK,    10'd2,    16'h0001);
        add_vector(ACT_FREE,   10'd2,    16'h0000, 1, STS_STALE, 10'd2,    16'h0001);
        add_vector(ACT_LOOKUP, 10'd2,    16'h0001, 1, STS_STALE, 10'd2,    16'h0001);
        add_vector(ACT_FREE,   10'd3,    16'h0000, 1, STS_OK,    10'd3,    16'h0001);
        add_vector(ACT_ALLOC,  10'd0,    16'h0000, 1, STS_OK,    10'd3,    16'h0001);
        add_vector(ACT_ALLOC,  10'd0,    16'h0000, 1, STS_OK,    10'd2,    16'h0001);
        add_vector(ACT_ALLOC,  10'd0,    16'h0000, 1, STS_OK,    10'd4,    16'h0000);
        add_vector(ACT_FREE,   10'd4,    16'h0000, 0, STS_OK,    10'd0,    16'h0000);
        add_vector(ACT_LOOKUP, 10'd4,    16'h0001, 0, STS_OK,    10'd0,    16'h0000);
        add_vector(ACT_CLEAR,  10'd1023, 16'hFFFF, 1, STS_OK,    10'd1023, 16'h0000);
        add_vector(ACT_LOOKUP, 10'd1,    16'h0000, 1, STS_RANGE, 10'd1,    16'h0000);
        add_vector(ACT_LOOKUP, 10'd0,    16'h0000, 1, STS_STALE, 10'd0,    16'h0000);
        add_vector(ACT_ALLOC,  10'd0,    16'h0000, 1, STS_OK,    10'd1,    16'h0000);
        add_vector(ACT_CLEAR,  10'd0,    16'h0000, 1, STS_OK,    10'd0,    16'h0000);
    endtask

    // ------------------------------------------------------------------
    // Sink side: random idle bursts, plus a long hold-off on request
    // ------------------------------------------------------------------
    int unsigned hold_left  = 0;
    int unsigned hold_taken = 0;
    int unsigned gap_left   = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != hold_taken) begin
            // start the long stall; the source keeps offering beats meanwhile
            hold_taken <= hold_reqs;
            hold_left  <= HOLD_LEN - 1;
            m_tready   <= 1'b0;
        end else if (gap_left != 0) begin
            m_tready <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            gap_left <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted beat with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[StatusW+IdW+GenW-1:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                fault_count++;
                mismatch_seen++;
                if (mismatch_seen <= MAX_SHOWN)
                    $display("unexpected result beat: sts=%0d id=%0d gen=%h",
                             got.sts, got.id, got.gen);
            end else begin
                want = pending_results.pop_front();
                if (got != want || m_tdata[BeatW-1:StatusW+IdW+GenW] != 0) begin
                    fault_count++;
                    mismatch_seen++;
                    if (mismatch_seen <= MAX_SHOWN)
                        $display("result %0d mismatch: want sts=%0d id=%0d gen=%h, got sts=%0d id=%0d gen=%h pad=%h",
                                 results_seen, want.sts, want.id, want.gen,
                                 got.sts, got.id, got.gen,
                                 m_tdata[BeatW-1:StatusW+IdW+GenW]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int unsigned     r;
        int unsigned     idx;
        handle_t         h;
        action_t         act;
        logic [GenW-1:0] g;

        for (int i = 0; i < SLOTS; i++) begin
            shadow_active[i] = 1'b0;
            shadow_gen[i]    = '0;
            shadow_link[i]   = '0;
        end
        shadow_clear();

        // hold reset, then release it on a falling edge
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table
        load_vectors();
        foreach (vectors[i])
            send_item(vectors[i].act, vectors[i].hid, vectors[i].hgen,
                      vectors[i].pinned, vectors[i].want);
        wait_drain();

        // Random part: mostly well-formed handle traffic, some noise
        for (int n = 0; n < RAND_ITEMS; n++) begin
            // leave stretches without any idling, and none at all near the end
            src_idle_on  = ((n % 150) < 100) && (n < RAND_ITEMS - QUIET_TAIL);
            sink_idle_on = ((n % 150) < 100) && (n < RAND_ITEMS - QUIET_TAIL);
            if (n == RAND_ITEMS / 2) begin
                // long receiver stall while the source keeps pushing
                hold_reqs++;
                for (int k = 0; k < 16; k++)
                    issue(ACT_ALLOC, IdW'($urandom), GenW'($urandom));
                wait_drain();
            end
            r = $urandom_range(0, 99);
            if (r < 35) begin
                issue(ACT_ALLOC, IdW'($urandom), GenW'($urandom));
            end else if (r < 78 && live_handles.size() != 0) begin
                idx = $urandom_range(0, live_handles.size() - 1);
                h   = live_handles[idx];
                issue(r < 60 ? ACT_FREE : ACT_LOOKUP, h.id, h.gen);
            end else if (r < 88) begin
                // stale handle: retired, or live with a wrong generation
                act = $urandom_range(0, 1) ? ACT_FREE : ACT_LOOKUP;
                if (retired_handles.size() != 0 && $urandom_range(0, 1)) begin
                    h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
                    issue(act, h.id, h.gen);
                end else if (live_handles.size() != 0) begin
                    h = live_handles[$urandom_range(0, live_handles.size() - 1)];
                    g = GenW'($urandom_range(1, 16'hFFFF));
                    issue(act, h.id, h.gen ^ g);
                end else begin
                    issue(act, IdW'($urandom_range(0, 7)), GenW'($urandom));
                end
            end else if (r < 97) begin
                act = $urandom_range(0, 1) ? ACT_FREE : ACT_LOOKUP;
                issue(act, IdW'($urandom), GenW'($urandom));
            end else begin
                issue(ACT_CLEAR, IdW'($urandom), GenW'($urandom));
                retired_handles.delete();
            end
        end

        // drop valid and let the last results through
        wait_drain();
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0)
            fault_count++;

        $display("Sent %0d items, checked %0d results (%0d mismatches)",
                 items_sent, results_seen, mismatch_seen);
        $display("Exercised reserved, out-of-range, stale and reused handles, clears and stalls");
        if (fault_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #200_000;
        $display("watchdog expired with %0d results outstanding", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
